@@ hdl/prefix_code_tree_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// Prefix code tree decoder assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_TREE_DECODER_MACROS_SVH
`define PREFIX_CODE_TREE_DECODER_MACROS_SVH

// same-cycle implication
`define PCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Prefix code tree decoder package
// Transaction payload types, operation and status codes, parameter defaults.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int NODE_COUNT_DEF    = 511;
  localparam int SYMBOL_COUNT_DEF  = 256;
  localparam int MAX_CODE_BITS_DEF = 24;

  localparam int CODE_W     = 24;
  localparam int CODE_EXT_W = 32;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  localparam logic [1:0] ST_DECODED  = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        entry_index;
    logic [CODE_W-1:0] code_bits;
    logic [4:0]        code_length;
    logic              stream_bit;
  } in_t;

  typedef struct packed {
    logic [7:0] symbol_index;
    logic [4:0] symbol_length;
    logic [1:0] status;
  } out_t;

endpackage

@@ hdl/prefix_code_tree_decoder.sv @@
// ----------------------------------------------------------------------------
// Prefix code tree decoder
// Binary code tree built by insert transactions, walked one stream bit per
// decode transaction; emits symbol and code length at marked nodes.
// ----------------------------------------------------------------------------
// Timing: one transaction at a time, paced by the node memory with its
// registered read port. A decode bit that lands on an inner node reads the
// link and then the leaf field; a missing branch goes to the output load after
// the link read, and a decoded symbol after link read, leaf read and length
// read. An insert reads one node per existing link, then writes the parent of
// the first missing link and one node per new node. There is no clearing pass:
// the root is rewritten on clear and in the init state after reset, and every
// node is written in full when it is allocated, so nodes at or above the free
// counter are never read.
`include "prefix_code_tree_decoder_macros.svh"

module prefix_code_tree_decoder #(
  parameter int NODE_COUNT    = pcd_pkg::NODE_COUNT_DEF,
  parameter int SYMBOL_COUNT  = pcd_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_BITS = pcd_pkg::MAX_CODE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pcd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output pcd_pkg::out_t out_data
);

  localparam int NI = $clog2(NODE_COUNT);
  localparam int NF = $clog2(NODE_COUNT + 1);
  localparam int SL = $clog2(SYMBOL_COUNT + 1);
  localparam int SA = $clog2(SYMBOL_COUNT);
  localparam int NW = 2 * NI + SL;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DEC_LINK, S_DEC_LEAF, S_DEC_LEN,
    S_INS_WALK, S_INS_LEAF, S_INS_NEW, S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [NI-1:0] cur_r, cur_nxt;
  logic [NF-1:0] next_free_r, next_free_nxt;
  logic [NI-1:0] node_r, node_nxt;
  logic [4:0]    j_r, j_nxt;
  pcd_pkg::in_t  item_r, item_nxt;
  pcd_pkg::out_t res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  pcd_pkg::out_t out_data_r, out_data_nxt;

  // node word: {one_child, zero_child, leaf (symbol+1, 0 = unmarked)}
  logic [NW-1:0] node_mem [NODE_COUNT];
  logic [NW-1:0] node_q;
  logic [NI-1:0] node_ra, node_wa;
  logic [NW-1:0] node_wd;
  logic          node_we;

  logic [4:0]    len_mem [SYMBOL_COUNT];
  logic [4:0]    len_q;
  logic [SA-1:0] len_ra;
  logic          len_we;

  logic [NI-1:0]             q_one, q_zero;
  logic [SL-1:0]             q_leaf, leaf_val, sym_val;
  logic [pcd_pkg::CODE_EXT_W-1:0] code_ext;
  logic                      ins_bit;
  logic [NI-1:0]             walk_link, dec_link, free_node, chain_node;
  logic [4:0]                missing;
  logic                      tree_full;

  assign q_one    = node_q[NW-1 -: NI];
  assign q_zero   = node_q[NW-1-NI -: NI];
  assign q_leaf   = node_q[SL-1:0];
  assign code_ext = {{(pcd_pkg::CODE_EXT_W - pcd_pkg::CODE_W){1'b0}}, item_r.code_bits};
  assign ins_bit  = code_ext[j_r];
  assign walk_link = ins_bit ? q_one : q_zero;
  assign dec_link  = item_r.stream_bit ? q_one : q_zero;
  assign leaf_val  = SL'(32'(item_r.entry_index) + 32'd1);
  assign sym_val   = q_leaf - SL'(1);
  assign free_node  = NI'(next_free_r);
  assign chain_node = NI'(32'(next_free_r) + 32'd1);
  assign missing    = item_r.code_length - j_r;
  assign tree_full  = (32'(next_free_r) > NODE_COUNT) ||
                      (32'(missing) > 32'(NODE_COUNT) - 32'(next_free_r));

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    next_free_nxt = next_free_r;
    node_nxt      = node_r;
    j_nxt         = j_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    node_ra       = '0;
    node_we       = 1'b0;
    node_wa       = '0;
    node_wd       = '0;
    len_ra        = '0;
    len_we        = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        node_we   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          case (in_data.operation)
            pcd_pkg::OP_CLEAR: begin
              node_we       = 1'b1;
              next_free_nxt = NF'(1);
              cur_nxt       = '0;
            end
            pcd_pkg::OP_INSERT: begin
              res_nxt = '0;
              if (in_data.code_length == 5'd0) begin
                res_nxt.status = pcd_pkg::ST_INSERTED;
                state_nxt      = S_EMIT;
              end else if (32'(in_data.code_length) > MAX_CODE_BITS ||
                           32'(in_data.entry_index) >= SYMBOL_COUNT) begin
                res_nxt.status = pcd_pkg::ST_INVALID;
                state_nxt      = S_EMIT;
              end else begin
                node_nxt  = '0;
                j_nxt     = 5'd0;
                state_nxt = S_INS_WALK;
              end
            end
            pcd_pkg::OP_DECODE: begin
              node_ra   = cur_r;
              state_nxt = S_DEC_LINK;
            end
            default: begin
            end
          endcase
        end
      end
      S_DEC_LINK: begin
        res_nxt = '0;
        if (dec_link == '0) begin
          cur_nxt        = '0;
          res_nxt.status = pcd_pkg::ST_INVALID;
          state_nxt      = S_EMIT;
        end else begin
          node_ra   = dec_link;
          node_nxt  = dec_link;
          state_nxt = S_DEC_LEAF;
        end
      end
      S_DEC_LEAF: begin
        if (q_leaf != '0) begin
          len_ra               = SA'(sym_val);
          res_nxt.symbol_index = 8'(sym_val);
          res_nxt.status       = pcd_pkg::ST_DECODED;
          cur_nxt              = '0;
          state_nxt            = S_DEC_LEN;
        end else begin
          cur_nxt   = node_r;
          state_nxt = S_IDLE;
        end
      end
      S_DEC_LEN: begin
        res_nxt.symbol_length = len_q;
        state_nxt             = S_EMIT;
      end
      S_INS_WALK: begin
        if (walk_link != '0) begin
          node_ra  = walk_link;
          node_nxt = walk_link;
          if (j_r == item_r.code_length - 5'd1) begin
            state_nxt = S_INS_LEAF;
          end else begin
            j_nxt = j_r + 5'd1;
          end
        end else if (tree_full) begin
          res_nxt.status = pcd_pkg::ST_FULL;
          state_nxt      = S_EMIT;
        end else begin
          // first missing link: the rest of the path is a fresh chain
          node_we   = 1'b1;
          node_wa   = node_r;
          node_wd   = ins_bit ? {free_node, q_zero, q_leaf} : {q_one, free_node, q_leaf};
          j_nxt     = j_r + 5'd1;
          state_nxt = S_INS_NEW;
        end
      end
      S_INS_LEAF: begin
        node_we        = 1'b1;
        node_wa        = node_r;
        node_wd        = {q_one, q_zero, leaf_val};
        len_we         = 1'b1;
        res_nxt.status = pcd_pkg::ST_INSERTED;
        state_nxt      = S_EMIT;
      end
      S_INS_NEW: begin
        node_we       = 1'b1;
        node_wa       = free_node;
        next_free_nxt = next_free_r + NF'(1);
        if (j_r == item_r.code_length) begin
          node_wd        = {{(2 * NI){1'b0}}, leaf_val};
          len_we         = 1'b1;
          res_nxt.status = pcd_pkg::ST_INSERTED;
          state_nxt      = S_EMIT;
        end else begin
          node_wd = ins_bit ? {chain_node, {(NI + SL){1'b0}}}
                            : {{NI{1'b0}}, chain_node, {SL{1'b0}}};
          j_nxt   = j_r + 5'd1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cur_r       <= '0;
      next_free_r <= NF'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    node_r     <= node_nxt;
    j_r        <= j_nxt;
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_q <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[SA'(item_r.entry_index)] <= item_r.code_length;
    end
    len_q <= len_mem[len_ra];
  end

  `PCD_ASSERT_NXT(a_clear_resets_walk, in_valid && !in_stall && in_data.operation == pcd_pkg::OP_CLEAR, next_free_r == NF'(1) && cur_r == '0, "clear did not reset free counter and walk")
  `PCD_ASSERT_IMP(a_cur_allocated, 1'b1, cur_r == '0 || NF'(cur_r) < next_free_r, "current node is not an allocated node")
  `PCD_ASSERT_NXT(a_insert_keeps_walk, state_r == S_INS_WALK || state_r == S_INS_LEAF || state_r == S_INS_NEW, $stable(cur_r), "insert disturbed the decode walk")
  `PCD_ASSERT_IMP(a_write_in_range, node_we, 32'(node_wa) < NODE_COUNT, "node write beyond node store")

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Prefix code tree decoder testbench
// Builds code tables with insert transactions, walks them bit by bit with
// decode transactions, and checks every result against a tree model kept in
// the bench. Runs directed corner cases and then random tables, tree-full
// bursts and stray bits under four sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NODES    = NODE_COUNT_DEF;
  localparam int SYMBOLS  = SYMBOL_COUNT_DEF;
  localparam int MAX_BITS = MAX_CODE_BITS_DEF;
  localparam int RAND_PER_PHASE = 250;
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  prefix_code_tree_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // bench copy of the code tree
  int         one_link [0:NODES-1];
  int         zero_link[0:NODES-1];
  int         node_mark[0:NODES-1];
  logic [4:0] code_len_of[0:SYMBOLS-1];
  int         free_node;
  int         walk_node;

  in_t  pend_q[$];
  out_t result_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int queued_total = 0;
  int accepted_total = 0;
  int gen_count = 0;
  int checked_count = 0;
  int err_count = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  function automatic void tree_clear();
    for (int i = 0; i < NODES; i++) begin
      one_link[i] = 0;
      zero_link[i] = 0;
      node_mark[i] = 0;
    end
    free_node = 1;
    walk_node = 0;
  endfunction

  function automatic logic [1:0] tree_insert(logic [7:0] sym, logic [23:0] code,
                                             logic [4:0] len);
    int node;
    int missing;
    int nxt;
    if (len == 0) return ST_INSERTED;
    if (len > MAX_BITS || sym >= SYMBOLS) return ST_INVALID;
    node = 0;
    missing = 0;
    for (int j = 0; j < len; j++) begin
      nxt = 0;
      if (missing == 0) nxt = code[j] ? one_link[node] : zero_link[node];
      if (nxt == 0) missing++;
      else node = nxt;
    end
    if (free_node > NODES || missing > NODES - free_node) return ST_FULL;
    node = 0;
    for (int j = 0; j < len; j++) begin
      if (code[j]) begin
        if (one_link[node] == 0) begin
          one_link[node] = free_node;
          free_node++;
        end
        node = one_link[node];
      end else begin
        if (zero_link[node] == 0) begin
          zero_link[node] = free_node;
          free_node++;
        end
        node = zero_link[node];
      end
    end
    node_mark[node] = sym + 1;
    code_len_of[sym] = len;
    return ST_INSERTED;
  endfunction

  // returns 1 when the transaction produces a result
  function automatic bit tree_step(in_t it, output out_t res);
    bit got;
    int nxt;
    int mk;
    res = '0;
    got = 1'b0;
    case (it.operation)
      OP_CLEAR: tree_clear();
      OP_INSERT: begin
        res.status = tree_insert(it.entry_index, it.code_bits, it.code_length);
        got = 1'b1;
      end
      OP_DECODE: begin
        nxt = it.stream_bit ? one_link[walk_node] : zero_link[walk_node];
        if (nxt == 0) begin
          walk_node = 0;
          res.status = ST_INVALID;
          got = 1'b1;
        end else begin
          mk = node_mark[nxt];
          if (mk != 0) begin
            walk_node = 0;
            res.symbol_index = 8'(mk - 1);
            res.symbol_length = code_len_of[mk - 1];
            res.status = ST_DECODED;
            got = 1'b1;
          end else begin
            walk_node = nxt;
          end
        end
      end
      default: ;
    endcase
    return got;
  endfunction

  // driver
  always @(posedge clk) begin
    out_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (tree_step(in_data, res)) result_q.push_back(res);
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pend_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void report_bad(string what, out_t exp_r, out_t act_r);
    err_count++;
    if (err_count <= 10)
      $display("%0t mismatch (%s): expected sym %0d len %0d st %0d, got sym %0d len %0d st %0d",
               $realtime, what, exp_r.symbol_index, exp_r.symbol_length, exp_r.status,
               act_r.symbol_index, act_r.symbol_length, act_r.status);
  endfunction

  // monitor
  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_bad("no result pending", '0, out_data);
        end else begin
          e = result_q.pop_front();
          checked_count++;
          status_seen[e.status]++;
          if (out_data.symbol_index !== e.symbol_index ||
              out_data.symbol_length !== e.symbol_length ||
              out_data.status !== e.status)
            report_bad("field", e, out_data);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic in_t noise_item(logic [1:0] op);
    in_t it;
    it.operation = op;
    it.entry_index = 8'($urandom);
    it.code_bits = 24'($urandom);
    it.code_length = 5'($urandom);
    it.stream_bit = 1'($urandom);
    return it;
  endfunction

  task automatic queue_item(in_t it);
    pend_q.push_back(it);
    queued_total++;
    if (it.operation != OP_UNUSED) gen_count++;
  endtask

  task automatic send_insert(logic [7:0] sym, logic [23:0] code, logic [4:0] len);
    in_t it;
    it = noise_item(OP_INSERT);
    it.entry_index = sym;
    it.code_bits = code;
    it.code_length = len;
    queue_item(it);
  endtask

  task automatic send_bit(logic b);
    in_t it;
    it = noise_item(OP_DECODE);
    it.stream_bit = b;
    queue_item(it);
  endtask

  initial begin
    logic [23:0] tbl_code[$];
    logic [4:0]  tbl_len[$];
    logic [23:0] code;
    logic [4:0]  len;
    int r;
    int k;
    int n;
    int pick;
    int target;

    tree_clear();
    for (int i = 0; i < SYMBOLS; i++) code_len_of[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase

      if (ph == 0) begin
        send_bit(1'b1);                          // empty tree
        send_insert(8'h12, 24'h0, 5'd0);         // zero length
        send_insert(8'h34, 24'hFFFFFF, 5'd31);   // too long
        send_insert(8'h56, 24'h0, 5'd25);
        send_insert(8'h00, 24'h0, 5'd1);
        send_insert(8'hFF, 24'hFFFFFF, 5'd24);
        send_bit(1'b0);
        send_insert(8'h07, 24'h0, 5'd1);         // overwrite mark
        send_bit(1'b0);
        send_insert(8'h09, 24'h2, 5'd2);         // path through a marked node
        send_bit(1'b0);
        send_insert(8'h3C, 24'h3, 5'd3);
        send_bit(1'b1);
        send_bit(1'b1);
        send_insert(8'hA5, 24'h5A5A5A, 5'd24);   // insert mid-walk
        send_bit(1'b0);
        queue_item(noise_item(OP_UNUSED));
        send_bit(1'b1);
        send_bit(1'b0);                          // missing branch
        queue_item(noise_item(OP_CLEAR));
        send_bit(1'b0);
      end

      target = gen_count + RAND_PER_PHASE;
      while (gen_count < target) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          queue_item(noise_item(OP_CLEAR));
          tbl_code.delete();
          tbl_len.delete();
        end else if (r < 12) begin
          // bursts of long codes that can run the node store out
          n = $urandom_range(20, 35);
          for (int i = 0; i < n; i++) begin
            code = 24'($urandom);
            len = 5'($urandom_range(18, MAX_BITS));
            send_insert(8'($urandom), code, len);
            tbl_code.push_back(code);
            tbl_len.push_back(len);
          end
        end else if (r < 35) begin
          k = $urandom_range(0, 99);
          if (k < 80) len = 5'($urandom_range(1, 8));
          else if (k < 95) len = 5'($urandom_range(9, MAX_BITS));
          else if (k < 97) len = 5'd0;
          else len = 5'($urandom_range(MAX_BITS + 1, 31));
          code = 24'($urandom);
          send_insert(8'($urandom), code, len);
          if (len != 0 && len <= MAX_BITS) begin
            tbl_code.push_back(code);
            tbl_len.push_back(len);
          end
        end else if (r < 80 && tbl_code.size() != 0) begin
          pick = $urandom_range(0, tbl_code.size() - 1);
          code = tbl_code[pick];
          len = tbl_len[pick];
          k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
          for (int j = 0; j < len; j++) begin
            if (j == k) send_insert(8'($urandom), 24'($urandom), 5'($urandom_range(1, 6)));
            send_bit(code[j]);
          end
        end else if (r < 96) begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) send_bit(1'($urandom));
        end else begin
          queue_item(noise_item(OP_UNUSED));
        end
        while (tbl_code.size() > 48) begin
          void'(tbl_code.pop_front());
          void'(tbl_len.pop_front());
        end
      end

      while (accepted_total != queued_total || result_q.size() != 0) @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (result_q.size() != 0) err_count++;
    $display("summary: %0d transactions accepted, %0d results checked", accepted_total,
             checked_count);
    $display("summary: decoded %0d, invalid %0d, inserted %0d, tree full %0d",
             status_seen[ST_DECODED], status_seen[ST_INVALID], status_seen[ST_INSERTED],
             status_seen[ST_FULL]);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("tb: errors");
    $finish;
  end

endmodule

@@ prefix_code_tree_decoder.f @@
+incdir+hdl
hdl/pcd_pkg.sv
hdl/prefix_code_tree_decoder.sv
sim/tb.sv
